/* rtl/ordered_key_set_unit_macros.svh */
// Assertion macros shared by the ordered key set RTL.
`ifndef ORDERED_KEY_SET_UNIT_MACROS_SVH
`define ORDERED_KEY_SET_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define OKS_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define OKS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define OKS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/oks_pkg.sv */
// Types and constants shared by the ordered key set modules.
package oks_pkg;

   localparam int KEY_PORT_WIDTH = 32;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_EXISTS = 3'd2;
   localparam logic [2:0] OP_NEXT   = 3'd3;
   localparam logic [2:0] OP_PREV   = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                      found;
      logic [KEY_PORT_WIDTH-1:0] neighbour_key;
      logic                      status;
   } rsp_type;

endpackage

/* rtl/oks_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module oks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/oks_engine.sv */
// Sequencer that scans, inserts into and deletes from the sorted key memory.
`include "ordered_key_set_unit_macros.svh"

module oks_engine #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_opcode,
   input  logic signed [oks_pkg::KEY_PORT_WIDTH-1:0] req_key,
   input  logic                                 rsp_free,
   output logic                                 done,
   output oks_pkg::rsp_type                     result
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = KEY_WIDTH;
   localparam int XW = (KW > oks_pkg::KEY_PORT_WIDTH) ? KW : oks_pkg::KEY_PORT_WIDTH;
   localparam logic [KW-1:0] KEY_SIGN = {1'b1, {(KW-1){1'b0}}};

   oks_pkg::state_type state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [KW-1:0] key_ff, key_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_idx_ff, pend_idx_in;
   logic          seen_ff, seen_in;
   logic          present_ff, present_in;
   logic          have_prev_ff, have_prev_in;
   logic [KW-1:0] prev_ff, prev_in;
   logic          have_next_ff, have_next_in;
   logic [KW-1:0] next_ff, next_in;
   logic          move_ff, move_in;
   logic [KW-1:0] carry_ff, carry_in;
   logic          status_ff, status_in;

   logic          mem_we;
   logic [AW-1:0] mem_wr_addr;
   logic [KW-1:0] mem_wr_data;
   logic          mem_re;
   logic [AW-1:0] mem_rd_addr;
   logic [KW-1:0] mem_rd_data;

   logic [XW-1:0] key_ext;
   logic          full;
   logic          last;
   logic          d_lt;
   logic          d_eq;
   logic [KW-1:0] nb_sel;
   logic [XW-1:0] nb_ext;

   oks_ram #(
      .WIDTH (KW),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_re),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oks_pkg::ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      issue_ff     <= issue_in;
      pend_idx_ff  <= pend_idx_in;
      seen_ff      <= seen_in;
      present_ff   <= present_in;
      have_prev_ff <= have_prev_in;
      prev_ff      <= prev_in;
      have_next_ff <= have_next_in;
      next_ff      <= next_in;
      move_ff      <= move_in;
      carry_ff     <= carry_in;
      status_ff    <= status_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      seen_in      = seen_ff;
      present_in   = present_ff;
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      have_next_in = have_next_ff;
      next_in      = next_ff;
      move_in      = move_ff;
      carry_in     = carry_ff;
      status_in    = status_ff;

      mem_we      = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = key_ff;
      mem_re      = 1'b0;
      mem_rd_addr = issue_ff[AW-1:0];

      req_stall = (state_ff != oks_pkg::ST_IDLE);
      done      = 1'b0;

      key_ext = XW'($unsigned(req_key));
      full    = (count_ff == CW'(CAPACITY));
      last    = ((CW'(pend_idx_ff) + CW'(1)) == count_ff);
      d_lt    = (mem_rd_data < key_ff);
      d_eq    = (mem_rd_data == key_ff);

      // A neighbour is reported only when one was found, else the key reads zero.
      case (op_ff)
         oks_pkg::OP_NEXT: nb_sel = have_next_ff ? (next_ff ^ KEY_SIGN) : '0;
         oks_pkg::OP_PREV: nb_sel = have_prev_ff ? (prev_ff ^ KEY_SIGN) : '0;
         default:          nb_sel = '0;
      endcase
      nb_ext = XW'(nb_sel);

      result.neighbour_key = '0;
      result.found         = 1'b0;
      result.status        = 1'b0;

      case (state_ff)
         oks_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in        = req_opcode;
               key_in       = key_ext[KW-1:0] ^ KEY_SIGN;
               issue_in     = '0;
               seen_in      = 1'b0;
               present_in   = 1'b0;
               have_prev_in = 1'b0;
               have_next_in = 1'b0;
               move_in      = 1'b0;
               status_in    = 1'b0;
               state_in     = (count_ff == '0) ? oks_pkg::ST_FINISH : oks_pkg::ST_SCAN;
            end
         end

         oks_pkg::ST_SCAN: begin
            // Read the next entry while the previous one is being handled.
            if (issue_ff < count_ff) begin
               mem_re      = 1'b1;
               issue_in    = issue_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[AW-1:0];
            end
            if (pend_ff) begin
               if (!seen_ff) begin
                  if (d_lt) begin
                     have_prev_in = 1'b1;
                     prev_in      = mem_rd_data;
                  end else begin
                     seen_in    = 1'b1;
                     present_in = d_eq;
                     case (op_ff)
                        oks_pkg::OP_INSERT: begin
                           if (!d_eq) begin
                              if (full) begin
                                 status_in = 1'b1;
                              end else begin
                                 mem_we      = 1'b1;
                                 mem_wr_addr = pend_idx_ff;
                                 mem_wr_data = key_ff;
                                 carry_in    = mem_rd_data;
                                 move_in     = 1'b1;
                              end
                           end
                        end
                        oks_pkg::OP_DELETE: begin
                           move_in = d_eq;
                        end
                        oks_pkg::OP_NEXT: begin
                           if (!d_eq) begin
                              have_next_in = 1'b1;
                              next_in      = mem_rd_data;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end else begin
                  case (op_ff)
                     oks_pkg::OP_INSERT: begin
                        // Ripple the displaced keys up by one entry.
                        if (move_ff) begin
                           mem_we      = 1'b1;
                           mem_wr_addr = pend_idx_ff;
                           mem_wr_data = carry_ff;
                           carry_in    = mem_rd_data;
                        end
                     end
                     oks_pkg::OP_DELETE: begin
                        // Pull the following keys down over the removed one.
                        if (move_ff) begin
                           mem_we      = 1'b1;
                           mem_wr_addr = pend_idx_ff - AW'(1);
                           mem_wr_data = mem_rd_data;
                        end
                     end
                     oks_pkg::OP_NEXT: begin
                        if (present_ff && !have_next_ff) begin
                           have_next_in = 1'b1;
                           next_in      = mem_rd_data;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               if (last) begin
                  state_in = oks_pkg::ST_FINISH;
               end
            end
         end

         oks_pkg::ST_FINISH: begin
            case (op_ff)
               oks_pkg::OP_INSERT: begin
                  result.status = status_ff | (!seen_ff & full);
               end
               oks_pkg::OP_EXISTS: begin
                  result.found = present_ff;
               end
               oks_pkg::OP_NEXT: begin
                  result.found = have_next_ff;
               end
               oks_pkg::OP_PREV: begin
                  result.found = have_prev_ff;
               end
               default: begin
               end
            endcase
            result.neighbour_key = nb_ext[oks_pkg::KEY_PORT_WIDTH-1:0];

            if (rsp_free) begin
               done     = 1'b1;
               state_in = oks_pkg::ST_IDLE;
               case (op_ff)
                  oks_pkg::OP_INSERT: begin
                     // Append at the top: either the last displaced key or the
                     // new key itself when it is larger than every stored one.
                     if (move_ff) begin
                        mem_we      = 1'b1;
                        mem_wr_addr = count_ff[AW-1:0];
                        mem_wr_data = carry_ff;
                        count_in    = count_ff + CW'(1);
                     end else if (!seen_ff && !full) begin
                        mem_we      = 1'b1;
                        mem_wr_addr = count_ff[AW-1:0];
                        mem_wr_data = key_ff;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  oks_pkg::OP_DELETE: begin
                     if (move_ff) begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: begin
            state_in = oks_pkg::ST_IDLE;
         end
      endcase
   end

   `OKS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY), "count above capacity")
   `OKS_ASSERT_IMPLIES(a_no_idle_write, clock, reset, state_ff == oks_pkg::ST_IDLE, !mem_we, "memory written while idle")
   `OKS_ASSERT_IMPLIES(a_write_in_range, clock, reset, mem_we, CW'(mem_wr_addr) <= count_ff, "write beyond packed region")
   `OKS_ASSERT_NEXT(a_count_only_at_finish, clock, reset, state_ff != oks_pkg::ST_FINISH, $stable(count_ff), "count changed outside finish")

endmodule

/* rtl/ordered_key_set_unit.sv */
// Top level of the ordered key set: sorted key store with successor and predecessor search.
//
// A request word carries req_opcode (insert, delete, exists, next greater,
// previous smaller) and a signed req_key; it is taken at a rising edge with
// req_valid high and req_stall low. Every request gives exactly one response
// word on rsp_found, rsp_neighbour_key and rsp_status, taken at an edge with
// rsp_valid high and rsp_stall low.
// Keys live in one synchronous RAM, sorted ascending and packed at the low
// entries. Each request reads the used entries one per cycle through the
// single read port of the key memory. Inserts and deletes shift the entries
// above the key within the same read pass, writing one entry behind the read.
// The next request is taken once the current one has finished.
// The response sits in an output register; while the receiver stalls, the
// block still accepts and scans the next request, and holds it at its final
// step until the held response word is taken.
// Reset empties the set at once by clearing the entry count; the memory
// contents are not cleared and need no clearing pass.
module ordered_key_set_unit #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic signed [31:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic signed [31:0] rsp_neighbour_key,
   output logic        rsp_status
);

   logic             rsp_valid_ff, rsp_valid_in;
   oks_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_free;
   logic             done;
   oks_pkg::rsp_type result;

   // The output register can take a new word when empty or being emptied.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   oks_engine #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_key    (req_key),
      .rsp_free   (rsp_free),
      .done       (done),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_ff.found;
   assign rsp_neighbour_key = rsp_ff.neighbour_key;
   assign rsp_status        = rsp_ff.status;

endmodule
